// File: sv/fir_q15_pkg.sv
// Shared types and constants for the Q15 FIR filter core.
// Holds field widths, operation codes and the controller/datapath command and status structs.
// No dependencies.
package fir_q15_pkg;

  // Payload field widths.
  localparam int DATA_W      = 16;
  localparam int IDX_W       = 6;
  localparam int TAP_W       = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Default delay line and coefficient table depth.
  localparam int MAX_TAPS_DEF = 64;

  // Tap count after reset.
  localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 7'd64;

  // Fixed-point constants: rounding bit, saturation bound and output shift.
  localparam int ROUND_SHIFT = 14;
  localparam int SAT_BITS    = 30;
  localparam int OUT_SHIFT   = 15;

  // Request kinds carried on in_tuser.
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic clr;       // write zero to both memories at the clear address
    logic wr_coef;   // store the latched coefficient
    logic wr_samp;   // push the latched sample and restart the tap walk
    logic rd;        // read one tap pair
    logic out_load;  // move the finished sum into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clear address is at the last entry
    logic busy;      // multiply-accumulate pipeline still holds taps
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

// File: sv/fir_q15_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the coefficient table and the sample delay line.
// No dependencies.
module fir_q15_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/fir_q15_ctrl.sv
// Controller for the Q15 FIR filter core: clearing pass, request decode and tap sequencing.
// Also holds the tap count register.
// Depends on fir_q15_pkg.
module fir_q15_ctrl #(
  parameter int MAX_TAPS = fir_q15_pkg::MAX_TAPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tuser,
  output logic                           in_tready,
  input  logic                           cfg_wr_en,
  input  logic [fir_q15_pkg::TAP_W-1:0]  cfg_wr_data,
  input  fir_q15_pkg::sts_t              sts,
  output fir_q15_pkg::cmd_t              cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_COEF,
    S_WR_SAMP,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t                          st_r, st_nxt;
  logic [fir_q15_pkg::TAP_W-1:0]   k_r, k_nxt;
  logic [fir_q15_pkg::TAP_W-1:0]   tap_count_r, tap_count_nxt;
  logic [fir_q15_pkg::TAP_W-1:0]   taps_eff;
  logic [fir_q15_pkg::TAP_W-1:0]   k_inc;

  // Tap count limited to the table depth.
  assign taps_eff = (32'(tap_count_r) > 32'(MAX_TAPS)) ?
                    fir_q15_pkg::TAP_W'(MAX_TAPS) : tap_count_r;
  assign k_inc    = k_r + 1'b1;

  // The configuration register takes every write.
  assign tap_count_nxt = cfg_wr_en ? cfg_wr_data : tap_count_r;

  // Requests are taken only while the controller waits in idle.
  assign in_tready = (st_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    st_nxt = st_r;
    k_nxt  = k_r;
    cmd    = '0;
    case (st_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          st_nxt = (in_tuser == fir_q15_pkg::OP_COEF) ? S_WR_COEF : S_WR_SAMP;
        end
      end
      S_WR_COEF: begin
        cmd.wr_coef = 1'b1;
        st_nxt      = S_IDLE;
      end
      S_WR_SAMP: begin
        cmd.wr_samp = 1'b1;
        k_nxt       = '0;
        st_nxt      = (taps_eff == '0) ? S_DRAIN : S_RUN;
      end
      S_RUN: begin
        cmd.rd = 1'b1;
        k_nxt  = k_inc;
        if (k_inc == taps_eff) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.busy && sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // State, tap counter and tap count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      k_r         <= '0;
      tap_count_r <= fir_q15_pkg::TAP_COUNT_RESET;
    end else begin
      st_r        <= st_nxt;
      k_r         <= k_nxt;
      tap_count_r <= tap_count_nxt;
    end
  end

  // A result is never loaded over one that is still waiting.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register is occupied");

  // Tap reads stay inside the active tap count.
  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (k_r < taps_eff))
    else $error("tap read beyond the active tap count");

  // No request is taken in the first cycle after reset; the clearing pass runs first.
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(!rst_n) && rst_n) |-> !in_tready)
    else $error("request accepted before the clearing pass");

endmodule

// File: sv/fir_q15_dp.sv
// Datapath for the Q15 FIR filter core: memories, pointers, multiply-accumulate and output register.
// Executes the controller's commands and reports pipeline and output status.
// Depends on fir_q15_pkg and fir_q15_ram.
module fir_q15_dp #(
  parameter int MAX_TAPS = fir_q15_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [fir_q15_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fir_q15_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                 out_tlast,
  input  fir_q15_pkg::cmd_t                    cmd,
  output fir_q15_pkg::sts_t                    sts
);

  localparam int DW    = fir_q15_pkg::DATA_W;
  localparam int IW    = fir_q15_pkg::IDX_W;
  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ACC_W = 2 * DW + $clog2(MAX_TAPS + 1) + 1;
  localparam int SB    = fir_q15_pkg::SAT_BITS;
  localparam int RS    = fir_q15_pkg::ROUND_SHIFT;
  localparam int OS    = fir_q15_pkg::OUT_SHIFT;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  localparam logic signed [ACC_W-1:0] ROUND_C =
    {{(ACC_W - RS - 1){1'b0}}, 1'b1, {RS{1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W - SB){1'b0}}, {SB{1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W - SB){1'b1}}, {SB{1'b0}}};

  // Latched request.
  logic [DW-1:0]             val_r;
  logic [IW-1:0]             idx_r;
  logic                      last_r;

  // Pointers and counters.
  logic [AW-1:0]             clr_addr_r;
  logic [AW-1:0]             wptr_r;
  logic [AW-1:0]             rd_ptr_r;
  logic [AW-1:0]             coef_addr_r;

  // Multiply-accumulate pipeline.
  logic                      v1_r, v2_r;
  logic signed [2*DW-1:0]    prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   sat_w;

  // Output register.
  logic                      out_valid_r;
  logic [DW-1:0]             out_data_r;
  logic                      out_last_r;

  // Memory ports.
  logic                      coef_we, samp_we;
  logic [AW-1:0]             coef_waddr, samp_waddr;
  logic [DW-1:0]             coef_wdata, samp_wdata;
  logic [DW-1:0]             coef_q, samp_q;
  logic                      idx_ok;

  // Coefficient writes past the table depth are dropped.
  assign idx_ok = ({26'd0, idx_r} < 32'(MAX_TAPS));

  // The clearing pass writes zero to the same address of both memories.
  assign coef_we    = cmd.clr | (cmd.wr_coef & idx_ok);
  assign coef_waddr = cmd.clr ? clr_addr_r : AW'(idx_r);
  assign coef_wdata = cmd.clr ? '0 : val_r;
  assign samp_we    = cmd.clr | cmd.wr_samp;
  assign samp_waddr = cmd.clr ? clr_addr_r : wptr_r;
  assign samp_wdata = cmd.clr ? '0 : val_r;

  fir_q15_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_addr_r),
    .rdata (coef_q)
  );

  fir_q15_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_TAPS)
  ) u_samp_ram (
    .clk   (clk),
    .we    (samp_we),
    .waddr (samp_waddr),
    .wdata (samp_wdata),
    .raddr (rd_ptr_r),
    .rdata (samp_q)
  );

  // Request payload capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r  <= in_tdata[IW-1:0];
      val_r  <= in_tdata[IW+DW-1:IW];
      last_r <= in_tlast;
    end
  end

  // Clear address, write pointer and the read walk from newest sample backward.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      wptr_r      <= '0;
      rd_ptr_r    <= '0;
      coef_addr_r <= '0;
    end else begin
      if (cmd.clr && clr_addr_r != LAST_ADDR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.wr_samp) begin
        rd_ptr_r    <= wptr_r;
        coef_addr_r <= '0;
        wptr_r      <= (wptr_r == LAST_ADDR) ? '0 : wptr_r + 1'b1;
      end else if (cmd.rd) begin
        rd_ptr_r    <= (rd_ptr_r == '0) ? LAST_ADDR : rd_ptr_r - 1'b1;
        coef_addr_r <= coef_addr_r + 1'b1;
      end
    end
  end

  // Pipeline valid flags: read data, then product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd;
      v2_r <= v1_r;
    end
  end

  // Product register and accumulator seeded with the rounding constant.
  always_ff @(posedge clk) begin
    prod_r <= $signed(coef_q) * $signed(samp_q);
    if (cmd.wr_samp) begin
      acc_r <= ROUND_C;
    end else if (v2_r) begin
      acc_r <= acc_r + {{(ACC_W - 2*DW){prod_r[2*DW-1]}}, prod_r};
    end
  end

  // Saturate the sum before the output shift.
  always_comb begin
    if (acc_r > SAT_HI) begin
      sat_w = SAT_HI;
    end else if (acc_r < SAT_LO) begin
      sat_w = SAT_LO;
    end else begin
      sat_w = acc_r;
    end
  end

  // Output register: loaded by the controller, emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= sat_w[OS+DW-1:OS];
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sts.clr_last = (clr_addr_r == LAST_ADDR);
  assign sts.busy     = v1_r | v2_r;
  assign sts.out_free = !out_valid_r || out_tready;

  // A result is only taken once every product has reached the accumulator.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!v1_r && !v2_r))
    else $error("result loaded with products still in flight");

  // The tap walk starts at the sample just written.
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_samp |=> (rd_ptr_r == $past(wptr_r)) && (coef_addr_r == '0))
    else $error("tap walk did not start at the newest sample");

  // A product only follows a read that returned data.
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("product stage valid without a preceding read");

endmodule

// File: sv/fir_filter_q15_core.sv
// Top level of the Q15 direct-form FIR filter core.
// Depends on fir_q15_pkg, fir_q15_ctrl, fir_q15_dp and fir_q15_ram.
//
// Usage:
//   The input stream carries two kinds of request, chosen by in_tuser. A sample
//   request (in_tuser = 0) pushes in_tdata's value into the delay line and
//   produces one filtered Q15 sample on the output stream, with in_tlast copied
//   to out_tlast. A coefficient request (in_tuser = 1) stores a tap weight at
//   coef_index and produces nothing. cfg_wr_en writes the tap count (0 to 127).
//   Sequencing: the sample is written to the delay line, then the single shared
//   multiplier takes one tap per cycle from the coefficient and delay line
//   memories (counts above MAX_TAPS act as MAX_TAPS), the pipeline drains and
//   the sum moves to the output register; the next request is accepted in the
//   cycle out_tvalid rises. A coefficient request is stored, then back to idle.
//   Reset: the tap count returns to 64, and a clearing pass zeroes both memories;
//   in_tready stays low until it ends. Configuration writes are taken during
//   the pass.
//   Stall: the result waits in an output register; one more sample request is
//   accepted and processed, and it holds in its final step until the receiver
//   takes the waiting result.
module fir_filter_q15_core #(
  parameter int MAX_TAPS = fir_q15_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Request stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fir_q15_pkg::IN_TDATA_W-1:0]   in_tdata,   // coef_index[5:0], value[21:6], zero[23:22]
  input  logic                                 in_tuser,   // operation
  input  logic                                 in_tlast,   // block_end
  // Result stream.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fir_q15_pkg::OUT_TDATA_W-1:0]  out_tdata,  // filtered_sample[15:0]
  output logic                                 out_tlast,  // block_end_out
  // Tap count register.
  input  logic                                 cfg_wr_en,
  input  logic [fir_q15_pkg::TAP_W-1:0]        cfg_wr_data
);

  fir_q15_pkg::cmd_t cmd;
  fir_q15_pkg::sts_t sts;

  // Sequencing and tap count.
  fir_q15_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tuser    (in_tuser),
    .in_tready   (in_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Memories, multiply-accumulate and output register.
  fir_q15_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// File: tb/sv/tb_fir_filter_q15_core.sv
// Self-checking testbench for the Q15 FIR filter core.
// Runs a directed table and then random phases against its own filter predictor.
// Depends on fir_q15_pkg and fir_filter_q15_core.
`timescale 1ns / 1ps

module tb_fir_filter_q15_core;

  localparam int SETTLE_CYCLES  = fir_q15_pkg::MAX_TAPS_DEF + 16;
  localparam int IDLE_LIMIT     = 5000;
  localparam int PHASE_COUNT    = 6;
  localparam int PHASE_ITEMS    = 255;
  localparam int DIRECTED_ROWS  = 24;
  localparam longint SAT_HI     = (longint'(1) <<< fir_q15_pkg::SAT_BITS) - 1;
  localparam longint SAT_LO     = -(longint'(1) <<< fir_q15_pkg::SAT_BITS);

  // Kinds of row in the directed table.
  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_COEF,
    ROW_TAPS
  } row_kind_t;

  // Receiver behavior for one stretch of cycles.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_MOSTLY,
    RX_PULSE
  } rx_mode_t;

  typedef struct {
    row_kind_t                             kind;
    logic [fir_q15_pkg::IDX_W-1:0]         idx;
    logic signed [fir_q15_pkg::DATA_W-1:0] val;      // sample, coefficient or tap count
    logic                                  last;
    logic                                  typed;    // expected output given in the row
    logic signed [fir_q15_pkg::DATA_W-1:0] exp_val;
  } stim_row_t;

  typedef struct packed {
    logic [fir_q15_pkg::DATA_W-1:0] sample;
    logic                           last;
  } filt_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [fir_q15_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // coef_index[5:0], value[21:6], zero[23:22]
  logic                                in_tuser = 1'b0; // operation
  logic                                in_tlast = 1'b0; // block_end
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [fir_q15_pkg::OUT_TDATA_W-1:0] out_tdata;       // filtered_sample[15:0]
  logic                                out_tlast;       // block_end_out
  logic                                cfg_wr_en = 1'b0;
  logic [fir_q15_pkg::TAP_W-1:0]       cfg_wr_data = '0;

  // Predictor state.
  logic signed [fir_q15_pkg::DATA_W-1:0] delay_hist [fir_q15_pkg::MAX_TAPS_DEF];
  logic signed [fir_q15_pkg::DATA_W-1:0] coef_tbl [fir_q15_pkg::MAX_TAPS_DEF];
  logic [fir_q15_pkg::TAP_W-1:0]         taps_in_use;
  filt_result_t                          pending_outputs [$];

  int       mismatches = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  int       rx_len = 0;
  rx_mode_t rx_mode = RX_STREAM;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Zero coefficients after reset give zero at both sample extremes.
    '{ROW_SAMPLE, 6'd0,  16'sh7fff, 1'b1, 1'b1, 16'sd0},
    '{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b0, 1'b1, 16'sd0},
    // A coefficient write ignores its block end flag.
    '{ROW_COEF,   6'd0,  16'sh8000, 1'b1, 1'b0, 16'sd0},
    '{ROW_COEF,   6'd63, 16'sh7fff, 1'b0, 1'b0, 16'sd0},
    // Most negative times most negative saturates high.
    '{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b0, 1'b1, 16'sh7fff},
    '{ROW_SAMPLE, 6'd0,  16'sh7fff, 1'b1, 1'b0, 16'sd0},
    '{ROW_TAPS,   6'd0,  16'sd1,    1'b0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 6'd0,  16'sd0,    1'b0, 1'b1, 16'sd0},
    '{ROW_SAMPLE, 6'd0,  16'shffff, 1'b0, 1'b0, 16'sd0},
    '{ROW_COEF,   6'd0,  16'sh7fff, 1'b0, 1'b0, 16'sd0},
    '{ROW_COEF,   6'd1,  16'sh7fff, 1'b0, 1'b0, 16'sd0},
    '{ROW_TAPS,   6'd0,  16'sd2,    1'b0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b0, 1'b0, 16'sd0},
    // Two full-scale negative products saturate low.
    '{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b1, 1'b1, 16'sh8000},
    // With no taps only the rounding constant is left.
    '{ROW_TAPS,   6'd0,  16'sd0,    1'b0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 6'd0,  16'sd12345, 1'b0, 1'b1, 16'sd0},
    // A tap count above the table depth is clipped to the depth.
    '{ROW_TAPS,   6'd0,  16'sd127,  1'b0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 6'd0,  16'sd1,    1'b0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 6'd0,  16'sh5555, 1'b1, 1'b0, 16'sd0},
    '{ROW_COEF,   6'd32, 16'shaaaa, 1'b1, 1'b0, 16'sd0},
    '{ROW_COEF,   6'd21, 16'sh5555, 1'b0, 1'b0, 16'sd0},
    '{ROW_TAPS,   6'd0,  16'sd64,   1'b0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 6'd0,  16'shaaaa, 1'b0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 6'd0,  16'sh7fff, 1'b1, 1'b0, 16'sd0}
  };

  fir_filter_q15_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shift one sample into the delay line and return the filtered Q15 output.
  function automatic logic [fir_q15_pkg::DATA_W-1:0] filter_sample(
    input logic signed [fir_q15_pkg::DATA_W-1:0] smp);
    longint acc;
    int     taps;
    for (int k = fir_q15_pkg::MAX_TAPS_DEF - 1; k > 0; k--) delay_hist[k] = delay_hist[k-1];
    delay_hist[0] = smp;
    taps = (taps_in_use > fir_q15_pkg::MAX_TAPS_DEF) ? fir_q15_pkg::MAX_TAPS_DEF
                                                     : int'(taps_in_use);
    acc = longint'(1) <<< fir_q15_pkg::ROUND_SHIFT;
    for (int k = 0; k < taps; k++) acc += longint'(coef_tbl[k]) * longint'(delay_hist[k]);
    if (acc > SAT_HI) acc = SAT_HI;
    else if (acc < SAT_LO) acc = SAT_LO;
    acc = acc >>> fir_q15_pkg::OUT_SHIFT;
    return acc[fir_q15_pkg::DATA_W-1:0];
  endfunction

  // Request values lean toward full scale, zero and minus one now and then.
  function automatic logic [fir_q15_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return fir_q15_pkg::DATA_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Offer one request, wait for acceptance, then update the predictor.
  task automatic push_request(input fir_q15_pkg::op_t op,
                              input logic [fir_q15_pkg::IDX_W-1:0] idx,
                              input logic signed [fir_q15_pkg::DATA_W-1:0] val,
                              input logic last, input logic typed,
                              input logic signed [fir_q15_pkg::DATA_W-1:0] typed_val);
    filt_result_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, val, idx};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (op == fir_q15_pkg::OP_SAMPLE) begin
      res.sample = filter_sample(val);
      if (typed) res.sample = typed_val;
      res.last = last;
      pending_outputs.push_back(res);
    end else begin
      coef_tbl[idx] = val;
    end
    // Bursts of back-to-back requests separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 120 : 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
    end
  endtask

  // Hold the sender until every result is back and the core has gone quiet.
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tap_count(input logic [fir_q15_pkg::TAP_W-1:0] taps);
    drain_outputs();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= taps;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    taps_in_use = taps;
  endtask

  // Receiver ready pattern: stretches of steady, random and pulsed acceptance.
  always @(posedge clk) begin
    if (rx_len == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_len  <= $urandom_range(8, 96);
    end else begin
      rx_len <= rx_len - 1;
    end
    case (rx_mode)
      RX_STREAM: out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
      default:   out_tready <= (rx_len % 24 == 0);
    endcase
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    filt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected result, sample", 0, int'($signed(out_tdata)));
      end else begin
        want = pending_outputs.pop_front();
        if (out_tdata !== want.sample)
          report_mismatch("filtered_sample", int'($signed(want.sample)),
                          int'($signed(out_tdata)));
        if (out_tlast !== want.last)
          report_mismatch("block_end_out", int'(want.last), int'(out_tlast));
      end
    end
  end

  // Watchdog on cycles without any accepted request, result or register write.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_fir_filter_q15_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [fir_q15_pkg::TAP_W-1:0] phase_taps;
    fir_q15_pkg::op_t              op;
    for (int k = 0; k < fir_q15_pkg::MAX_TAPS_DEF; k++) begin
      delay_hist[k] = '0;
      coef_tbl[k]   = '0;
    end
    taps_in_use = fir_q15_pkg::TAP_COUNT_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_TAPS:
          set_tap_count(directed_rows[r].val[fir_q15_pkg::TAP_W-1:0]);
        ROW_COEF:
          push_request(fir_q15_pkg::OP_COEF, directed_rows[r].idx, directed_rows[r].val,
                       directed_rows[r].last, 1'b0, '0);
        default:
          push_request(fir_q15_pkg::OP_SAMPLE, directed_rows[r].idx, directed_rows[r].val,
                       directed_rows[r].last, directed_rows[r].typed,
                       directed_rows[r].exp_val);
      endcase
    end

    // Random phases, each at its own tap count.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: phase_taps = 7'd1;
        1: phase_taps = 7'd64;
        2: phase_taps = fir_q15_pkg::TAP_W'($urandom_range(65, 127));
        default: phase_taps = fir_q15_pkg::TAP_W'($urandom_range(2, 63));
      endcase
      set_tap_count(phase_taps);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Let everything in flight come back once, midway through phase 3.
        if (p == 3 && i == PHASE_ITEMS / 2) drain_outputs();
        op = ($urandom_range(0, 3) == 0) ? fir_q15_pkg::OP_COEF : fir_q15_pkg::OP_SAMPLE;
        push_request(op,
                     fir_q15_pkg::IDX_W'($urandom_range(0, fir_q15_pkg::MAX_TAPS_DEF - 1)),
                     pick_value(), ($urandom_range(0, 3) == 0), 1'b0, '0);
      end
    end

    drain_outputs();
    if (mismatches == 0) begin
      $display("tb_fir_filter_q15_core passed");
    end else begin
      $display("tb_fir_filter_q15_core failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/fir_q15_pkg.sv
sv/fir_q15_ram.sv
sv/fir_q15_ctrl.sv
sv/fir_q15_dp.sv
sv/fir_filter_q15_core.sv
tb/sv/tb_fir_filter_q15_core.sv
